// ===== rtl/imh_pkg.sv =====
// Package for the indexed min-heap unit.
// Holds shared widths, operation codes and status codes; no dependencies.
`default_nettype none

package imh_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int ITEM_BITS      = 10;
    localparam int ITEM_IDS       = 1024;
    localparam int IO_KEY_BITS    = 32;
    localparam int COUNT_OUT_BITS = 11;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_UPDATE  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_FULL        = 3'd2,
        ST_PRESENT     = 3'd3,
        ST_NOT_PRESENT = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/imh_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/indexed_min_heap_unit.sv =====
// Indexed binary min-heap unit: top level and sift sequencer.
// Depends on imh_pkg and imh_ram.
`default_nettype none

// Usage:
// A command word (i_func, i_item, i_key) is taken at a rising edge with start
// high and busy low. busy stays high while the command runs. Its single result
// word (o_item_out, o_key_out, o_status, o_count_out) is shown for exactly one
// cycle with o_valid high; the receiver cannot stall, so it must take it then.
// Heap entries {item, key} live in a slot RAM, kept as two identical banks so
// both children of a slot are read in the same cycle; an item RAM holds the
// presence bit and slot of each item id. Every sift level is one RAM read, then
// one compare and write back of the moving hole. An update runs an upward pass
// before a downward pass. A new command is taken in the cycle the result is
// shown. After reset all 1024 item RAM entries are cleared, one entry per
// cycle; busy is high during that pass.

module indexed_min_heap_unit #(
    parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            i_func,
    input  wire logic [imh_pkg::ITEM_BITS-1:0]         i_item,
    input  wire logic signed [imh_pkg::IO_KEY_BITS-1:0] i_key,
    output logic                                       o_valid,
    output logic [imh_pkg::ITEM_BITS-1:0]              o_item_out,
    output logic signed [imh_pkg::IO_KEY_BITS-1:0]     o_key_out,
    output logic [2:0]                                 o_status,
    output logic [imh_pkg::COUNT_OUT_BITS-1:0]         o_count_out
);

    localparam int IB = imh_pkg::ITEM_BITS;
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int HW = IB + KEY_BITS;
    localparam int MW = SW + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_UP_CHK, S_UP_CMP, S_DN_CHK, S_DN_CMP
    } t_state;

    function automatic logic key_gt(input logic signed [KEY_BITS-1:0] a,
                                    input logic signed [KEY_BITS-1:0] b);
        return a > b;
    endfunction

    t_state                      r_state;
    logic [IB-1:0]               r_clr;
    logic [1:0]                  r_func;
    logic [IB-1:0]               r_item;
    logic signed [KEY_BITS-1:0]  r_key;
    logic [SW-1:0]               r_cnt;
    logic [SW-1:0]               r_p;
    logic [IB-1:0]               r_e_item;
    logic signed [KEY_BITS-1:0]  r_e_key;
    logic                        r_down;
    logic                        r_valid;
    logic [IB-1:0]               r_res_item;
    logic signed [KEY_BITS-1:0]  r_res_key;
    imh_pkg::t_status            r_res_status;

    logic          h_we;
    logic [SW-1:0] h_waddr;
    logic [HW-1:0] h_wdata;
    logic [SW-1:0] h_ra0, h_ra1;
    logic [HW-1:0] h_rd0, h_rd1;
    logic          m_we;
    logic [IB-1:0] m_waddr;
    logic [MW-1:0] m_wdata;
    logic [MW-1:0] m_rd;

    logic [SW:0]   w_two_p;
    logic          w_dn_go;
    logic          w_sel_r;
    logic [HW-1:0] w_child;
    logic [SW-1:0] w_c;
    logic          w_up_mv;
    logic          w_dn_mv;

    logic signed [KEY_BITS-1:0] w_rd0_key, w_rd1_key, w_child_key;

    assign w_rd0_key   = h_rd0[KEY_BITS-1:0];
    assign w_rd1_key   = h_rd1[KEY_BITS-1:0];
    assign w_two_p     = {r_p, 1'b0};
    assign w_dn_go     = w_two_p <= {1'b0, r_cnt};
    assign w_sel_r     = (w_two_p < {1'b0, r_cnt}) && key_gt(w_rd0_key, w_rd1_key);
    assign w_child     = w_sel_r ? h_rd1 : h_rd0;
    assign w_child_key = w_child[KEY_BITS-1:0];
    assign w_c         = {r_p[SW-2:0], w_sel_r};
    assign w_up_mv     = key_gt(w_rd0_key, r_e_key);
    assign w_dn_mv     = key_gt(r_e_key, w_child_key);

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_p;
        h_wdata = {r_e_item, r_e_key};
        h_ra0   = {r_p[SW-2:0], 1'b0};
        h_ra1   = {r_p[SW-2:0], 1'b1};
        m_we    = 1'b0;
        m_waddr = r_e_item;
        m_wdata = {1'b1, r_p};
        case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = '0;
            end
            S_IDLE: begin
                h_ra0 = SW'(1);
                h_ra1 = r_cnt;
            end
            S_LOOK: begin
                if (r_func == imh_pkg::FUNC_EXTRACT && r_cnt != '0) begin
                    m_we    = 1'b1;
                    m_waddr = h_rd0[HW-1:KEY_BITS];
                    m_wdata = '0;
                end
            end
            S_UP_CHK: begin
                h_ra0 = r_p >> 1;
                if (r_p <= SW'(1) && !r_down) begin
                    h_we = 1'b1;
                    m_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                if (w_up_mv) begin
                    h_we    = 1'b1;
                    h_wdata = h_rd0;
                    m_we    = 1'b1;
                    m_waddr = h_rd0[HW-1:KEY_BITS];
                end else if (!r_down) begin
                    h_we = 1'b1;
                    m_we = 1'b1;
                end
            end
            S_DN_CHK: begin
                if (!w_dn_go) begin
                    h_we = 1'b1;
                    m_we = 1'b1;
                end
            end
            S_DN_CMP: begin
                h_we = 1'b1;
                m_we = 1'b1;
                if (w_dn_mv) begin
                    h_wdata = w_child;
                    m_waddr = w_child[HW-1:KEY_BITS];
                end
            end
            default: begin
            end
        endcase
    end

    imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY + 1)) u_heap0 (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_ra0), .o_rdata(h_rd0)
    );

    imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY + 1)) u_heap1 (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_ra1), .o_rdata(h_rd1)
    );

    imh_ram #(.WIDTH(MW), .DEPTH(imh_pkg::ITEM_IDS)) u_items (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(i_item), .o_rdata(m_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_item  <= i_item;
                        r_key   <= KEY_BITS'(i_key);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_res_item   <= r_item;
                    r_res_key    <= r_key;
                    r_res_status <= imh_pkg::ST_OK;
                    r_e_item     <= r_item;
                    r_e_key      <= r_key;
                    r_down       <= (r_func == imh_pkg::FUNC_UPDATE);
                    r_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                    case (r_func)
                        imh_pkg::FUNC_INSERT: begin
                            if (m_rd[SW]) begin
                                r_res_status <= imh_pkg::ST_PRESENT;
                            end else if ({1'b0, r_cnt} >= (SW + 1)'(CAPACITY)) begin
                                r_res_status <= imh_pkg::ST_FULL;
                            end else begin
                                r_cnt   <= r_cnt + 1'b1;
                                r_p     <= r_cnt + 1'b1;
                                r_valid <= 1'b0;
                                r_state <= S_UP_CHK;
                            end
                        end
                        imh_pkg::FUNC_EXTRACT: begin
                            if (r_cnt == '0) begin
                                r_res_status <= imh_pkg::ST_EMPTY;
                                r_res_item   <= '0;
                                r_res_key    <= '0;
                            end else begin
                                r_res_item <= h_rd0[HW-1:KEY_BITS];
                                r_res_key  <= w_rd0_key;
                                r_e_item   <= h_rd1[HW-1:KEY_BITS];
                                r_e_key    <= w_rd1_key;
                                r_cnt      <= r_cnt - 1'b1;
                                r_p        <= SW'(1);
                                if (r_cnt != SW'(1)) begin
                                    r_valid <= 1'b0;
                                    r_state <= S_DN_CHK;
                                end
                            end
                        end
                        imh_pkg::FUNC_UPDATE: begin
                            if (!m_rd[SW]) begin
                                r_res_status <= imh_pkg::ST_NOT_PRESENT;
                            end else begin
                                r_p     <= m_rd[SW-1:0];
                                r_valid <= 1'b0;
                                r_state <= S_UP_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_UP_CHK: begin
                    if (r_p > SW'(1)) begin
                        r_state <= S_UP_CMP;
                    end else if (r_down) begin
                        r_state <= S_DN_CHK;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_UP_CMP: begin
                    if (w_up_mv) begin
                        r_p     <= r_p >> 1;
                        r_state <= S_UP_CHK;
                    end else if (r_down) begin
                        r_state <= S_DN_CHK;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DN_CHK: begin
                    if (w_dn_go) begin
                        r_state <= S_DN_CMP;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DN_CMP: begin
                    if (w_dn_mv) begin
                        r_p     <= w_c;
                        r_state <= S_DN_CHK;
                    end else begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_item_out  = r_res_item;
    assign o_key_out   = imh_pkg::IO_KEY_BITS'(r_res_key);
    assign o_status    = r_res_status;
    assign o_count_out = imh_pkg::COUNT_OUT_BITS'(r_cnt);

endmodule

`default_nettype wire

// ===== rtl/imh_checker.sv =====
// Port-level checker for the indexed min-heap unit, bound to the top level.
// Depends on imh_pkg.
`default_nettype none

module imh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [2:0]  o_status,
    input wire logic [10:0] o_count_out
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but unit not busy");

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == imh_pkg::ST_EMPTY) |-> (o_count_out == '0))
        else $error("empty status with nonzero count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= imh_pkg::ST_NOT_PRESENT))
        else $error("undefined status code");

endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_valid(o_valid),
    .o_status(o_status),
    .o_count_out(o_count_out)
);

`default_nettype wire
